FILE: rtl/tlg_pkg.sv
// Shared types and constants for the toroidal life generation step block.
// No dependencies; imported by tlg_req_if, tlg_cfg_if, tlg_life_row, tlg_seq and the top level.
package tlg_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int REQ_W     = 2;
  localparam int COORD_W   = 6;

  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd10;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd10;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADVANCE = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_ADVANCE,
    ST_POST
  } state_t;

  typedef struct packed {
    logic cell_val;
    logic status;
  } tlg_res_t;

endpackage

FILE: rtl/tlg_req_if.sv
// Request channel: valid/ready plus request word fields.
// Depends on tlg_pkg.
interface tlg_req_if;
  import tlg_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic               cell_in;

  modport source (output valid, output req_type, output row, output col, output cell_in,
                  input ready);
  modport sink   (input valid, input req_type, input row, input col, input cell_in,
                  output ready);
endinterface

FILE: rtl/tlg_rsp_if.sv
// Result channel: valid/ready plus cell value and status.
// No package dependency.
interface tlg_rsp_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic status;

  modport source (output valid, output cell_out, output status, input ready);
  modport sink   (input valid, input cell_out, input status, output ready);
endinterface

FILE: rtl/tlg_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on tlg_pkg.
interface tlg_cfg_if;
  import tlg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tlg_board_mem.sv
// Board store: simple dual-port RAM, one write and one registered read per cycle.
// No package dependency.
module tlg_board_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tlg_life_row.sv
// Next-generation row from a three-row window, columns wrapping at cols_eff.
// Depends on tlg_pkg.
module tlg_life_row #(
  parameter int MAX_COLS = 64,
  localparam int CIW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic [tlg_pkg::CFG_W-1:0] cols_eff,
  input  logic [MAX_COLS-1:0]       w_up,
  input  logic [MAX_COLS-1:0]       w_mid,
  input  logic [MAX_COLS-1:0]       w_dn,
  output logic [MAX_COLS-1:0]       nxt
);
  import tlg_pkg::*;

  logic [CFG_W-1:0] cols_m1;
  logic             up_last, mid_last, dn_last;

  assign cols_m1  = cols_eff - 7'd1;
  // left neighbor of column 0 is the last column in use
  assign up_last  = w_up[cols_m1[CIW-1:0]];
  assign mid_last = w_mid[cols_m1[CIW-1:0]];
  assign dn_last  = w_dn[cols_m1[CIW-1:0]];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    localparam int LI = (c == 0) ? 0 : c - 1;
    localparam int RI = (c == MAX_COLS - 1) ? 0 : c + 1;
    localparam logic [CFG_W-1:0] CX = CFG_W'(c);

    logic       is_last;
    logic       lu, lm, ld, ru, rm, rd;
    logic [3:0] n;

    assign is_last = (CX == cols_m1);
    assign lu = (c == 0) ? up_last  : w_up[LI];
    assign lm = (c == 0) ? mid_last : w_mid[LI];
    assign ld = (c == 0) ? dn_last  : w_dn[LI];
    assign ru = is_last ? w_up[0]  : w_up[RI];
    assign rm = is_last ? w_mid[0] : w_mid[RI];
    assign rd = is_last ? w_dn[0]  : w_dn[RI];

    // tiny boards count coinciding neighbors once per position
    assign n = {3'b0, lu} + {3'b0, ru} + {3'b0, lm} + {3'b0, rm} +
               {3'b0, ld} + {3'b0, rd} + {3'b0, w_up[c]} + {3'b0, w_dn[c]};

    assign nxt[c] = (CX < cols_eff) &&
                    ((n == BIRTH_COUNT) || (w_mid[c] && (n == SURVIVE_COUNT)));
  end

endmodule

FILE: rtl/tlg_seq.sv
// Request sequencer: clear pass, cell read/modify/write, generation sweep.
// Depends on tlg_pkg, tlg_req_if and tlg_life_row.
module tlg_seq #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int AW      = RW + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tlg_pkg::CFG_W-1:0] rows_eff,
  input  logic [tlg_pkg::CFG_W-1:0] cols_eff,
  tlg_req_if.sink                   req,
  output logic                      res_valid,
  output tlg_pkg::tlg_res_t         res,
  input  logic                      res_ready,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [MAX_COLS-1:0]       mem_wdata,
  output logic [AW-1:0]             mem_raddr,
  input  logic [MAX_COLS-1:0]       mem_rdata
);
  import tlg_pkg::*;

  localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RMAX = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam int KW   = $clog2(RMAX + 3);

  state_t               state_r, state_nxt;
  logic                 cur_buf_r, cur_buf_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [RW-1:0]        rd_row_r, rd_row_nxt;
  logic [RW-1:0]        wr_row_r, wr_row_nxt;
  logic [KW-1:0]        iss_cnt_r, iss_cnt_nxt;
  logic [1:0]           sh_cnt_r, sh_cnt_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 win_vld_r, win_vld_nxt;
  tlg_res_t             res_r, res_nxt;

  logic [REQ_W-1:0]     req_r;
  logic [COORD_W-1:0]   row_r;
  logic [COORD_W-1:0]   col_r;
  logic                 cell_r;
  logic [MAX_COLS-1:0]  win_r [3];

  logic [RW-1:0]        last_row;
  logic [KW-1:0]        iss_lim;
  logic                 issue;
  logic                 adv_done;
  logic                 oor;
  logic [CIW-1:0]       bit_idx;
  logic [MAX_COLS-1:0]  set_word;
  logic [MAX_COLS-1:0]  life_out;

  tlg_life_row #(.MAX_COLS(MAX_COLS)) u_life (
    .cols_eff (cols_eff),
    .w_up     (win_r[0]),
    .w_mid    (win_r[1]),
    .w_dn     (win_r[2]),
    .nxt      (life_out)
  );

  assign last_row  = RW'(rows_eff - 7'd1);
  // sweep reads row R-1, then 0..R-1, then 0 again: R+2 reads
  assign iss_lim   = KW'(rows_eff) + KW'(2);
  assign oor       = ({1'b0, row_r} >= rows_eff) || ({1'b0, col_r} >= cols_eff);
  assign bit_idx   = CIW'(col_r);
  assign req.ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_POST);
  assign res       = res_r;

  always_comb begin
    set_word          = mem_rdata;
    set_word[bit_idx] = cell_r;
  end

  always_comb begin
    state_nxt    = state_r;
    cur_buf_nxt  = cur_buf_r;
    clr_addr_nxt = clr_addr_r;
    rd_row_nxt   = rd_row_r;
    wr_row_nxt   = wr_row_r;
    iss_cnt_nxt  = iss_cnt_r;
    sh_cnt_nxt   = sh_cnt_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = {cur_buf_r, RW'(row_r)};
    mem_wdata    = set_word;
    mem_raddr    = {cur_buf_r, RW'(req.row)};
    issue        = 1'b0;
    adv_done     = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          case (req.req_type) inside
            REQ_WRITE, REQ_READ: begin
              state_nxt = ST_ACCESS;
            end
            REQ_ADVANCE: begin
              state_nxt   = ST_ADVANCE;
              rd_row_nxt  = last_row;
              wr_row_nxt  = '0;
              iss_cnt_nxt = '0;
              sh_cnt_nxt  = '0;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_POST;
            end
          endcase
        end
      end
      ST_ACCESS: begin
        // row word was read at accept; it is valid this cycle
        mem_we           = (req_r == REQ_WRITE) && !oor;
        res_nxt.status   = oor;
        res_nxt.cell_val = (req_r == REQ_READ) && !oor && mem_rdata[bit_idx];
        state_nxt        = ST_POST;
      end
      ST_ADVANCE: begin
        mem_raddr = {cur_buf_r, rd_row_r};
        issue     = (iss_cnt_r < iss_lim);
        if (issue) begin
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          rd_row_nxt  = (rd_row_r == last_row) ? '0 : rd_row_r + 1'b1;
        end
        if (rd_vld_r && (sh_cnt_r != 2'd3)) begin
          sh_cnt_nxt = sh_cnt_r + 2'd1;
        end
        if (win_vld_r) begin
          // sweep reads one buffer and writes the other: no overlap
          mem_we     = 1'b1;
          mem_waddr  = {~cur_buf_r, wr_row_r};
          mem_wdata  = life_out;
          wr_row_nxt = wr_row_r + 1'b1;
          if (wr_row_r == last_row) begin
            adv_done    = 1'b1;
            cur_buf_nxt = ~cur_buf_r;
            res_nxt     = '0;
            state_nxt   = ST_POST;
          end
        end
      end
      ST_POST: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rd_vld_nxt  = issue;
    win_vld_nxt = rd_vld_r && (sh_cnt_r >= 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      cur_buf_r  <= 1'b0;
      clr_addr_r <= '0;
      rd_row_r   <= '0;
      wr_row_r   <= '0;
      iss_cnt_r  <= '0;
      sh_cnt_r   <= '0;
      rd_vld_r   <= 1'b0;
      win_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_buf_r  <= cur_buf_nxt;
      clr_addr_r <= clr_addr_nxt;
      rd_row_r   <= rd_row_nxt;
      wr_row_r   <= wr_row_nxt;
      iss_cnt_r  <= iss_cnt_nxt;
      sh_cnt_r   <= sh_cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      win_vld_r  <= win_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if ((state_r == ST_IDLE) && req.valid) begin
      req_r  <= req.req_type;
      row_r  <= req.row;
      col_r  <= req.col;
      cell_r <= req.cell_in;
    end
    if (rd_vld_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= mem_rdata;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("board written while idle");

  a_sweep_dst: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ADVANCE) && mem_we) |-> (mem_waddr[AW-1] != cur_buf_r))
    else $error("sweep wrote the current buffer");

  a_window_full: assert property (@(posedge clk) disable iff (!rst_n)
    win_vld_r |-> (sh_cnt_r == 2'd3))
    else $error("window used before three rows loaded");

  a_buf_swap: assert property (@(posedge clk) disable iff (!rst_n)
    adv_done |=> (cur_buf_r != $past(cur_buf_r)))
    else $error("buffers did not swap after sweep");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ACCESS) && mem_we) |-> !res_nxt.status)
    else $error("cell write with coordinate out of range");
`endif

endmodule

FILE: rtl/toroidal_life_generation_step_top.sv
// Top level: config registers, result output register, sequencer and board RAM.
// Depends on tlg_pkg, tlg_req_if, tlg_rsp_if, tlg_cfg_if, tlg_board_mem, tlg_seq.
//
// Usage:
//   cfg_ch  - register writes (index 0 rows in use, 1 columns in use), always ready.
//             Sizes are clamped to 1..MAX_ROWS / 1..MAX_COLS; write only while idle.
//   in_ch   - request words: write cell, read cell, advance one generation.
//   out_ch  - one result word per request: cell value on a good read, status 1
//             for a row or column outside the size in use.
// Flow: a read or write result passes through the ACCESS and POST states to the
//   output register. An advance sweeps rows through the RAM read port, one row per
//   cycle, and then posts its result. One request is in work at a time; a new one is
//   taken as soon as the previous result is handed to the output register, even
//   while that word waits for the receiver.
// Reset: synchronous, active low. Afterwards a clearing pass writes all
//   2 * 2**clog2(MAX_ROWS) RAM rows dead (128 at the default), while in_ch is not
//   ready. Sizes reset to 10 x 10.
// Stall: a held output word blocks the next result; the sequencer waits for it.
module toroidal_life_generation_step_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  tlg_cfg_if.sink   cfg_ch,
  tlg_req_if.sink   in_ch,
  tlg_rsp_if.source out_ch
);
  import tlg_pkg::*;

  localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW        = RW + 1;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [CFG_W-1:0] ROWS_CAP = (MAX_ROWS > 127) ? 7'd127 : CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_CAP = CFG_W'(MAX_COLS);

  logic [CFG_W-1:0]    rows_r, cols_r;
  logic [CFG_W-1:0]    rows_eff, cols_eff;
  logic                out_valid_r;
  tlg_res_t            out_res_r;
  logic                res_valid, res_ready;
  tlg_res_t            res;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata, mem_rdata;

  assign rows_eff = (rows_r == '0) ? 7'd1 : ((rows_r > ROWS_CAP) ? ROWS_CAP : rows_r);
  assign cols_eff = (cols_r == '0) ? 7'd1 : ((cols_r > COLS_CAP) ? COLS_CAP : cols_r);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ROWS: rows_r <= cfg_ch.data;
        CFG_COLS: cols_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // output word register parts the sequencer from the receiver
  assign res_ready       = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.cell_out = out_res_r.cell_val;
  assign out_ch.status   = out_res_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  tlg_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .rows_eff  (rows_eff),
    .cols_eff  (cols_eff),
    .req       (in_ch),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tlg_board_mem #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (MAX_COLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: sim/tb.sv
// Testbench for toroidal_life_generation_step_top: a directed table and then random
// requests over several board sizes, each result word checked against a local model.
// Depends on rtl/tlg_pkg.sv, the three channel interfaces and the top-level RTL.
`timescale 1ns / 100ps

module tb;
  import tlg_pkg::*;

  localparam int MAX_ROWS        = 64;
  localparam int MAX_COLS        = 64;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 84;
  localparam int NUM_PHASES      = 9;
  localparam int DIR_N           = 25;
  localparam int MAX_SHOWN       = 10;
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               cell_in;
    logic               typed;
    logic               exp_cell;
    logic               exp_status;
  } life_vec_t;

  logic clk;
  logic rst_n;

  tlg_cfg_if cfg_ch ();
  tlg_req_if in_ch ();
  tlg_rsp_if out_ch ();

  toroidal_life_generation_step_top #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the board and the size registers
  logic [MAX_COLS-1:0] shadow_board [2*MAX_ROWS];
  logic                shadow_buf;
  logic [CFG_W-1:0]    shadow_rows;
  logic [CFG_W-1:0]    shadow_cols;

  tlg_res_t life_exp_q [$];

  int burst_left;
  int n_sent;
  int n_gens;
  int n_oor;
  int n_checked;
  int n_bad;
  int cyc;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int rows_eff();
    if (shadow_rows == 0) return 1;
    if (shadow_rows > MAX_ROWS) return MAX_ROWS;
    return int'(shadow_rows);
  endfunction

  function automatic int cols_eff();
    if (shadow_cols == 0) return 1;
    if (shadow_cols > MAX_COLS) return MAX_COLS;
    return int'(shadow_cols);
  endfunction

  // Applies one request to the shadow board and returns the word it should produce.
  function automatic tlg_res_t predict_cell(logic [REQ_W-1:0] kind, logic [COORD_W-1:0] row,
                                            logic [COORD_W-1:0] col, logic cell_in);
    tlg_res_t            res;
    int                  nr, nc, src, dst, up, dn, lf, rt, n, idx;
    logic [MAX_COLS-1:0] w0, w1, w2, nxt;
    res = '0;
    nr  = rows_eff();
    nc  = cols_eff();
    idx = (shadow_buf ? MAX_ROWS : 0) + int'(row);
    if (kind == REQ_WRITE || kind == REQ_READ) begin
      if (int'(row) >= nr || int'(col) >= nc) begin
        res.status = 1'b1;
      end else if (kind == REQ_WRITE) begin
        shadow_board[idx][col] = cell_in;
      end else begin
        res.cell_val = shadow_board[idx][col];
      end
    end else if (kind == REQ_ADVANCE) begin
      src = shadow_buf ? MAX_ROWS : 0;
      dst = shadow_buf ? 0 : MAX_ROWS;
      for (int r = 0; r < nr; r++) begin
        up  = (r == 0) ? nr - 1 : r - 1;
        dn  = (r == nr - 1) ? 0 : r + 1;
        w0  = shadow_board[src + up];
        w1  = shadow_board[src + r];
        w2  = shadow_board[src + dn];
        nxt = '0;
        for (int c = 0; c < nc; c++) begin
          lf = (c == 0) ? nc - 1 : c - 1;
          rt = (c == nc - 1) ? 0 : c + 1;
          // tiny boards: wrapped positions may alias, each position still counts once
          n  = int'(w0[lf]) + int'(w0[c]) + int'(w0[rt]) + int'(w1[lf]) + int'(w1[rt])
             + int'(w2[lf]) + int'(w2[c]) + int'(w2[rt]);
          if (n == BIRTH_COUNT || (w1[c] && n == SURVIVE_COUNT)) nxt[c] = 1'b1;
        end
        shadow_board[dst + r] = nxt;
      end
      shadow_buf = ~shadow_buf;
    end
    return res;
  endfunction

  task automatic send_req(logic [REQ_W-1:0] kind, logic [COORD_W-1:0] row,
                          logic [COORD_W-1:0] col, logic cell_in,
                          logic typed, tlg_res_t typed_res);
    tlg_res_t pred;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.row      <= row;
    in_ch.col      <= col;
    in_ch.cell_in  <= cell_in;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    pred = predict_cell(kind, row, col, cell_in);
    life_exp_q.push_back(typed ? typed_res : pred);
    n_sent++;
    if (kind == REQ_ADVANCE) n_gens++;
    if (pred.status) n_oor++;
  endtask

  // hold off the sender until every outstanding word has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (life_exp_q.size() != 0);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] wdata);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= wdata;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_ROWS) shadow_rows = wdata;
    else shadow_cols = wdata;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: always ready, random stalls, then ready one cycle in four
  initial begin
    out_ch.ready <= 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      case ((cyc / 400) % 3)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 9) < 6);
        default: out_ch.ready <= (cyc % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    tlg_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (life_exp_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_SHOWN)
          $display("unexpected result word: cell %0b status %0b", out_ch.cell_out, out_ch.status);
      end else begin
        want = life_exp_q.pop_front();
        n_checked++;
        if (out_ch.cell_out !== want.cell_val || out_ch.status !== want.status) begin
          n_bad++;
          if (n_bad <= MAX_SHOWN)
            $display("mismatch on word %0d: cell exp %0b got %0b, status exp %0b got %0b",
                     n_checked, want.cell_val, out_ch.cell_out, want.status, out_ch.status);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout with %0d words outstanding", life_exp_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    life_vec_t        dir_tab [DIR_N];
    logic [CFG_W-1:0] size_rows [NUM_PHASES];
    logic [CFG_W-1:0] size_cols [NUM_PHASES];
    logic [REQ_W-1:0]   kind;
    logic [COORD_W-1:0] row, col;
    logic               cell_in;
    int                 pick, nr, nc;

    // tiny boards, full size, clamped sizes (zero and all ones), mixed shapes
    size_rows = '{7'd1, 7'd2, 7'd64, 7'd0, 7'd127, 7'd65, 7'd3, 7'd5, 7'd10};
    size_cols = '{7'd1, 7'd2, 7'd64, 7'd0, 7'd127, 7'd3, 7'd65, 7'd7, 7'd10};

    // kind, row, col, cell_in, typed, exp cell, exp status; board is 10 x 10 here
    dir_tab = '{
      '{REQ_READ,     6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_READ,     6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 1'b1},
      '{REQ_WRITE,    6'd9,  6'd9,  1'b1, 1'b1, 1'b0, 1'b0},
      '{REQ_WRITE,    6'd10, 6'd0,  1'b1, 1'b1, 1'b0, 1'b1},
      '{REQ_WRITE,    6'd0,  6'd10, 1'b1, 1'b1, 1'b0, 1'b1},
      '{REQ_READ,     6'd9,  6'd9,  1'b0, 1'b1, 1'b1, 1'b0},
      '{REQ_READ,     6'd10, 6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
      '{REQ_RESERVED, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
      '{REQ_READ,     6'd0,  6'd10, 1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_WRITE,    6'd0,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0},
      '{REQ_WRITE,    6'd0,  6'd9,  1'b1, 1'b0, 1'b0, 1'b0},
      '{REQ_WRITE,    6'd9,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0},
      '{REQ_WRITE,    6'd4,  6'd4,  1'b1, 1'b0, 1'b0, 1'b0},
      '{REQ_WRITE,    6'd5,  6'd4,  1'b1, 1'b0, 1'b0, 1'b0},
      '{REQ_WRITE,    6'd6,  6'd4,  1'b1, 1'b0, 1'b0, 1'b0},
      '{REQ_ADVANCE,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
      '{REQ_READ,     6'd5,  6'd3,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_READ,     6'd5,  6'd5,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_READ,     6'd4,  6'd4,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_READ,     6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_ADVANCE,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_READ,     6'd4,  6'd4,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_WRITE,    6'd9,  6'd9,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_READ,     6'd9,  6'd9,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_ADVANCE,  6'd5,  6'd5,  1'b0, 1'b0, 1'b0, 1'b0}
    };

    for (int i = 0; i < 2*MAX_ROWS; i++) shadow_board[i] = '0;
    shadow_buf  = 1'b0;
    shadow_rows = ROWS_RESET;
    shadow_cols = COLS_RESET;
    burst_left  = 0;
    n_sent      = 0;
    n_gens      = 0;
    n_oor       = 0;
    n_checked   = 0;
    n_bad       = 0;

    rst_n          <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_ROWS;
    cfg_ch.data    <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_WRITE;
    in_ch.row      <= '0;
    in_ch.col      <= '0;
    in_ch.cell_in  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      send_req(dir_tab[i].kind, dir_tab[i].row, dir_tab[i].col, dir_tab[i].cell_in,
               dir_tab[i].typed,
               '{cell_val: dir_tab[i].exp_cell, status: dir_tab[i].exp_status});
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        size_rows[p] = CFG_W'($urandom_range(1, 64));
        size_cols[p] = CFG_W'($urandom_range(1, 64));
      end
      cfg_write(CFG_ROWS, size_rows[p]);
      cfg_write(CFG_COLS, size_cols[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick    = $urandom_range(0, 99);
        nr      = rows_eff();
        nc      = cols_eff();
        row     = COORD_W'($urandom_range(0, nr - 1));
        col     = COORD_W'($urandom_range(0, nc - 1));
        cell_in = 1'($urandom_range(0, 1));
        if (pick < 40) begin
          kind = REQ_WRITE;
        end else if (pick < 75) begin
          kind = REQ_READ;
        end else if (pick < 87) begin
          kind = REQ_ADVANCE;
          row  = COORD_W'($urandom_range(0, 63));
          col  = COORD_W'($urandom_range(0, 63));
        end else if (pick < 95) begin
          // coordinate just past or well past the size in use
          kind = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
          if ($urandom_range(0, 1) && nr < MAX_ROWS) row = COORD_W'($urandom_range(nr, 63));
          else if (nc < MAX_COLS) col = COORD_W'($urandom_range(nc, 63));
          else row = COORD_W'($urandom_range(0, 63));
        end else begin
          kind = REQ_RESERVED;
          row  = COORD_W'($urandom_range(0, 63));
          col  = COORD_W'($urandom_range(0, 63));
        end
        send_req(kind, row, col, cell_in, 1'b0, '0);
      end
      drain_results();
    end

    $display("sent %0d requests (%0d generations, %0d out-of-range) over %0d board sizes",
             n_sent, n_gens, n_oor, NUM_PHASES + 1);
    $display("checked %0d result words, %0d mismatches", n_checked, n_bad);
    if (n_bad == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/tlg_pkg.sv
rtl/tlg_req_if.sv
rtl/tlg_rsp_if.sv
rtl/tlg_cfg_if.sv
rtl/tlg_board_mem.sv
rtl/tlg_life_row.sv
rtl/tlg_seq.sv
rtl/toroidal_life_generation_step_top.sv
sim/tb.sv
